### sv/tdd_pkg.sv
// ----------------------------------------------------------------------------
// Thermometer display driver package
// Shared widths, reset values, codes, types and the seven-segment table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int NUM_DIGITS      = 3;

  localparam int TEMP_W      = 12;
  localparam int THRESH_W    = 12;
  localparam int WIDTH_W     = 15;
  localparam int DUTY_W      = 16;
  localparam int DIGIT_W     = 4;
  localparam int SEG_W       = 7;
  localparam int EN_W        = 3;
  localparam int SCAN_W      = 2;
  localparam int LEVEL_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int OUT_TDATA_W = 64;

  localparam logic [TEMP_W-1:0] FULL_SCALE_TENTHS = 12'd3300;
  localparam logic [DUTY_W-1:0] DUTY_MAX          = 16'hFFFF;

  localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST  = 12'd230;
  localparam logic [THRESH_W-1:0] MID_THRESHOLD_RST  = 12'd250;
  localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST = 12'd270;
  localparam logic [WIDTH_W-1:0]  WIDTH_CLOSED_RST   = 15'd1000;
  localparam logic [WIDTH_W-1:0]  WIDTH_MID_RST      = 15'd1500;
  localparam logic [WIDTH_W-1:0]  WIDTH_OPEN_RST     = 15'd2000;

  // Scan positions and the digit enables that go with them.
  localparam logic [SCAN_W-1:0] SCAN_TENTHS = 2'd0;
  localparam logic [SCAN_W-1:0] SCAN_UNITS  = 2'd1;
  localparam logic [SCAN_W-1:0] SCAN_TENS   = 2'd2;

  localparam logic [EN_W-1:0] EN_OFF    = 3'b000;
  localparam logic [EN_W-1:0] EN_TENTHS = 3'b001;
  localparam logic [EN_W-1:0] EN_UNITS  = 3'b010;
  localparam logic [EN_W-1:0] EN_TENS   = 3'b100;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } tdd_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 3'd0,
    REG_MID_THRESHOLD  = 3'd1,
    REG_HIGH_THRESHOLD = 3'd2,
    REG_WIDTH_CLOSED   = 3'd3,
    REG_WIDTH_MID      = 3'd4,
    REG_WIDTH_OPEN     = 3'd5
  } tdd_reg_t;

  typedef struct packed {
    logic [THRESH_W-1:0] low;
    logic [THRESH_W-1:0] mid;
    logic [THRESH_W-1:0] high;
    logic [WIDTH_W-1:0]  w_closed;
    logic [WIDTH_W-1:0]  w_mid;
    logic [WIDTH_W-1:0]  w_open;
  } tdd_cfg_t;

  // Load enables of the pipeline registers, input register first.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
  } tdd_adv_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
    logic [DIGIT_W-1:0] tenths;
    logic [TEMP_W-1:0]  temp;
    logic               red;
    logic               green;
    logic               blue;
    logic [DUTY_W-1:0]  duty;
  } tdd_meas_t;

  // Segments a..g in bits 0..6; anything that is not a decimal digit is dark.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    case (d)
      4'd0:    return 7'h3F;
      4'd1:    return 7'h06;
      4'd2:    return 7'h5B;
      4'd3:    return 7'h4F;
      4'd4:    return 7'h66;
      4'd5:    return 7'h6D;
      4'd6:    return 7'h7D;
      4'd7:    return 7'h07;
      4'd8:    return 7'h7F;
      4'd9:    return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

endpackage

### sv/thermometer_display_driver.sv
// ----------------------------------------------------------------------------
// Thermometer display driver
// A result passes the input register, scale product, full-scale division,
// digit/duty products, duty reciprocal product and the result register.
// Throughput: one item per cycle; tready falls only when every stage is full
// and the result is not taken. Reset clears the pipeline, sets the registers
// to their defaults, darkens the display and turns the LEDs and duty off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermometer_display_driver #(
  parameter int SAMPLE_BITS = tdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // segments, digit_enable, dot, red_level, green_level, blue_level,
  // servo_duty, temp_tenths
  output logic [tdd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [tdd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tdd_pkg::tdd_cfg_t  cfg;
  tdd_pkg::tdd_adv_t  adv;
  tdd_pkg::tdd_meas_t meas;
  tdd_pkg::tdd_req_t  kind_a, kind_b, kind_c, kind_d, kind_e;

  logic v_a, v_b, v_c, v_d, v_e, out_valid;
  logic en_out, commit;

  logic [tdd_pkg::TEMP_W-1:0]  temp_c;
  logic [tdd_pkg::SEG_W-1:0]   segments;
  logic [tdd_pkg::EN_W-1:0]    digit_enable;
  logic                        dot;
  logic [tdd_pkg::LEVEL_W-1:0] red_level, green_level, blue_level;
  logic [tdd_pkg::DUTY_W-1:0]  servo_duty;
  logic [tdd_pkg::TEMP_W-1:0]  temp_tenths;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low      <= tdd_pkg::LOW_THRESHOLD_RST;
      cfg.mid      <= tdd_pkg::MID_THRESHOLD_RST;
      cfg.high     <= tdd_pkg::HIGH_THRESHOLD_RST;
      cfg.w_closed <= tdd_pkg::WIDTH_CLOSED_RST;
      cfg.w_mid    <= tdd_pkg::WIDTH_MID_RST;
      cfg.w_open   <= tdd_pkg::WIDTH_OPEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tdd_pkg::REG_LOW_THRESHOLD:  cfg.low      <= cfg_data[tdd_pkg::THRESH_W-1:0];
        tdd_pkg::REG_MID_THRESHOLD:  cfg.mid      <= cfg_data[tdd_pkg::THRESH_W-1:0];
        tdd_pkg::REG_HIGH_THRESHOLD: cfg.high     <= cfg_data[tdd_pkg::THRESH_W-1:0];
        tdd_pkg::REG_WIDTH_CLOSED:   cfg.w_closed <= cfg_data[tdd_pkg::WIDTH_W-1:0];
        tdd_pkg::REG_WIDTH_MID:      cfg.w_mid    <= cfg_data[tdd_pkg::WIDTH_W-1:0];
        tdd_pkg::REG_WIDTH_OPEN:     cfg.w_open   <= cfg_data[tdd_pkg::WIDTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or its occupant moves on, so bubbles close up.
  always_comb begin
    en_out = !out_valid || m_axis_tready;
    adv.e  = !v_e || en_out;
    adv.d  = !v_d || adv.e;
    adv.c  = !v_c || adv.d;
    adv.b  = !v_b || adv.c;
    adv.a  = !v_a || adv.b;
    commit = v_e && en_out;
  end

  assign s_axis_tready = adv.a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      v_e       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.a) begin
        v_a <= s_axis_tvalid;
      end
      if (adv.b) begin
        v_b <= v_a;
      end
      if (adv.c) begin
        v_c <= v_b;
      end
      if (adv.d) begin
        v_d <= v_c;
      end
      if (adv.e) begin
        v_e <= v_d;
      end
      if (en_out) begin
        out_valid <= v_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.a) begin
      kind_a <= tdd_pkg::tdd_req_t'(s_axis_tuser);
    end
    if (adv.b) begin
      kind_b <= kind_a;
    end
    if (adv.c) begin
      kind_c <= kind_b;
    end
    if (adv.d) begin
      kind_d <= kind_c;
    end
    if (adv.e) begin
      kind_e <= kind_d;
    end
  end

  tdd_convert #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_convert (
    .clk    (clk),
    .adv    (adv),
    .sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .temp   (temp_c)
  );

  tdd_classify u_classify (
    .clk  (clk),
    .adv  (adv),
    .cfg  (cfg),
    .temp (temp_c),
    .meas (meas)
  );

  tdd_display u_display (
    .clk          (clk),
    .rst          (rst),
    .commit       (commit),
    .kind         (kind_e),
    .meas         (meas),
    .segments     (segments),
    .digit_enable (digit_enable),
    .dot          (dot),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .servo_duty   (servo_duty),
    .temp_tenths  (temp_tenths)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, temp_tenths, servo_duty, blue_level, green_level,
                          red_level, dot, digit_enable, segments};

endmodule

### sv/tdd_convert.sv
// ----------------------------------------------------------------------------
// Converter reading to tenths of a degree
// Input register, scale by 3300, then exact division by the full-scale code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdd_convert #(
  parameter int SAMPLE_BITS = tdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  tdd_pkg::tdd_adv_t            adv,
  input  logic [SAMPLE_BITS-1:0]       sample,
  output logic [tdd_pkg::TEMP_W-1:0]   temp
);

  localparam int TW = tdd_pkg::TEMP_W;
  localparam int XW = SAMPLE_BITS + TW;
  localparam int EW = TW + 1;
  localparam logic [XW:0] FULL = {{(XW + 1 - SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [XW-1:0]          prod_q;
  logic [TW-1:0]          temp_q;
  logic [XW:0]            sum_w;
  logic [EW-1:0]          quot_est;
  logic [XW:0]            back_w;
  logic [XW:0]            rem_w;
  logic [TW-1:0]          temp_next;

  always_ff @(posedge clk) begin
    if (adv.a) begin
      sample_q <= sample;
    end
    if (adv.b) begin
      prod_q <= XW'(sample_q) * XW'(tdd_pkg::FULL_SCALE_TENTHS);
    end
    if (adv.c) begin
      temp_q <= temp_next;
    end
  end

  // With F = 2^N - 1 and x = q*F + r, q = (x + q) >> N. Using x >> N in place
  // of q leaves the estimate at most one low, which the remainder test fixes.
  always_comb begin
    sum_w    = {1'b0, prod_q} + (XW + 1)'(prod_q[XW-1:SAMPLE_BITS]);
    quot_est = sum_w[XW:SAMPLE_BITS];
    back_w   = ((XW + 1)'(quot_est) << SAMPLE_BITS) - (XW + 1)'(quot_est);
    rem_w    = {1'b0, prod_q} - back_w;
    if (rem_w >= FULL) begin
      temp_next = TW'(quot_est + EW'(1));
    end else begin
      temp_next = TW'(quot_est);
    end
  end

  assign temp = temp_q;

endmodule

### sv/tdd_classify.sv
// ----------------------------------------------------------------------------
// Temperature classification, digit split and servo duty
// Two register stages: constant products, then the duty reciprocal product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdd_classify (
  input  logic                       clk,
  input  tdd_pkg::tdd_adv_t          adv,
  input  tdd_pkg::tdd_cfg_t          cfg,
  input  logic [tdd_pkg::TEMP_W-1:0] temp,
  output tdd_pkg::tdd_meas_t         meas
);

  localparam int TW       = tdd_pkg::TEMP_W;
  localparam int WW       = tdd_pkg::WIDTH_W;
  localparam int DW       = tdd_pkg::DUTY_W;
  localparam int DIV_SH   = 19;
  localparam int P10_W    = TW + 16;
  localparam int P100_W   = TW + 13;
  localparam int D10_W    = P10_W - DIV_SH;
  localparam int H_W      = P100_W - DIV_SH;
  localparam int SCALED_W = WW + 16;
  localparam int NUM_W    = SCALED_W - 5;
  localparam int RECIP_W  = 27;
  localparam int DUTY_SH  = 36;
  localparam int ZW       = NUM_W + RECIP_W;
  localparam int RAW_W    = ZW - DUTY_SH;

  // floor(t/10) and floor(t/100) as reciprocal products, exact for 12-bit t.
  localparam logic [15:0] MUL10  = 16'd52429;
  localparam logic [12:0] MUL100 = 13'd5243;
  // The period 20000 is 32 * 625: a shift by five, then 1/625 scaled by 2^36.
  localparam logic [RECIP_W-1:0] RECIP625 = 27'd109951163;

  logic [TW-1:0]       temp_d;
  logic [P10_W-1:0]    p10_d;
  logic [P100_W-1:0]   p100_d;
  logic [NUM_W-1:0]    num_d;
  logic                red_d, green_d, blue_d;

  logic [TW-1:0]       temp_e;
  logic [D10_W-1:0]    d10_e;
  logic [H_W-1:0]      h_e;
  logic [RAW_W-1:0]    duty_e;
  logic                red_e, green_e, blue_e;

  logic                below_low, below_mid, below_high;
  logic                red_w, green_w, blue_w;
  logic [WW-1:0]       width_sel;
  logic [SCALED_W-1:0] scaled_w;
  logic [ZW-1:0]       duty_prod;
  logic [TW-1:0]       tenths_w;
  logic [D10_W-1:0]    units_w;

  function automatic logic [tdd_pkg::DIGIT_W-1:0] mod10(input logic [H_W-1:0] v);
    logic [H_W-1:0] r;
    r = v;
    if (r >= H_W'(60)) begin
      r = r - H_W'(60);
    end else if (r >= H_W'(50)) begin
      r = r - H_W'(50);
    end else if (r >= H_W'(40)) begin
      r = r - H_W'(40);
    end else if (r >= H_W'(30)) begin
      r = r - H_W'(30);
    end else if (r >= H_W'(20)) begin
      r = r - H_W'(20);
    end else if (r >= H_W'(10)) begin
      r = r - H_W'(10);
    end
    return r[tdd_pkg::DIGIT_W-1:0];
  endfunction

  // The tests run in this order even when the thresholds are not ascending.
  always_comb begin
    below_low  = temp < cfg.low;
    below_mid  = temp < cfg.mid;
    below_high = temp < cfg.high;
    red_w   = 1'b0;
    green_w = 1'b0;
    blue_w  = 1'b0;
    if (below_low) begin
      blue_w = 1'b1;
    end else if (below_mid) begin
      green_w = 1'b1;
    end else if (below_high) begin
      red_w   = 1'b1;
      green_w = 1'b1;
    end else begin
      red_w = 1'b1;
    end
    if (below_low) begin
      width_sel = cfg.w_closed;
    end else if (below_mid || below_high) begin
      width_sel = cfg.w_mid;
    end else begin
      width_sel = cfg.w_open;
    end
    scaled_w = {width_sel, 16'b0} - SCALED_W'(width_sel);
  end

  assign duty_prod = ZW'(num_d) * ZW'(RECIP625);

  always_ff @(posedge clk) begin
    if (adv.d) begin
      temp_d  <= temp;
      p10_d   <= P10_W'(temp) * P10_W'(MUL10);
      p100_d  <= P100_W'(temp) * P100_W'(MUL100);
      num_d   <= scaled_w[SCALED_W-1:5];
      red_d   <= red_w;
      green_d <= green_w;
      blue_d  <= blue_w;
    end
    if (adv.e) begin
      temp_e  <= temp_d;
      d10_e   <= p10_d[P10_W-1:DIV_SH];
      h_e     <= p100_d[P100_W-1:DIV_SH];
      duty_e  <= duty_prod[ZW-1:DUTY_SH];
      red_e   <= red_d;
      green_e <= green_d;
      blue_e  <= blue_d;
    end
  end

  always_comb begin
    tenths_w    = temp_e - TW'(d10_e) * TW'(10);
    units_w     = d10_e - D10_W'(h_e) * D10_W'(10);
    meas.tenths = tenths_w[tdd_pkg::DIGIT_W-1:0];
    meas.units  = units_w[tdd_pkg::DIGIT_W-1:0];
    meas.tens   = mod10(h_e);
    meas.temp   = temp_e;
    meas.red    = red_e;
    meas.green  = green_e;
    meas.blue   = blue_e;
    // Widths above the period would overflow the duty; it saturates instead.
    if (duty_e > RAW_W'(tdd_pkg::DUTY_MAX)) begin
      meas.duty = tdd_pkg::DUTY_MAX;
    end else begin
      meas.duty = duty_e[DW-1:0];
    end
  end

endmodule

### sv/tdd_display.sv
// ----------------------------------------------------------------------------
// Display scan and result state
// Holds the digits, LED levels, duty and shown pattern; they form the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdd_display (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        commit,
  input  tdd_pkg::tdd_req_t           kind,
  input  tdd_pkg::tdd_meas_t          meas,
  output logic [tdd_pkg::SEG_W-1:0]   segments,
  output logic [tdd_pkg::EN_W-1:0]    digit_enable,
  output logic                        dot,
  output logic [tdd_pkg::LEVEL_W-1:0] red_level,
  output logic [tdd_pkg::LEVEL_W-1:0] green_level,
  output logic [tdd_pkg::LEVEL_W-1:0] blue_level,
  output logic [tdd_pkg::DUTY_W-1:0]  servo_duty,
  output logic [tdd_pkg::TEMP_W-1:0]  temp_tenths
);

  localparam int SW = tdd_pkg::SCAN_W;
  localparam logic [SW:0] SCAN_LAST = (SW + 1)'(tdd_pkg::NUM_DIGITS - 1);

  logic [SW-1:0]                  scan_index;
  logic [tdd_pkg::DIGIT_W-1:0]    digit_tenths, digit_units, digit_tens;
  logic [tdd_pkg::TEMP_W-1:0]     temp_reg;
  logic                           red_on, green_on, blue_on;
  logic [tdd_pkg::DUTY_W-1:0]     duty_reg;
  logic [tdd_pkg::SEG_W-1:0]      seg_reg;
  logic [tdd_pkg::EN_W-1:0]       en_reg;
  logic                           dot_reg;

  logic [SW-1:0]                  scan_next;
  logic [tdd_pkg::SEG_W-1:0]      seg_next;
  logic [tdd_pkg::EN_W-1:0]       en_next;
  logic                           dot_next;

  // Scan index three never occurs from reset; it blanks the enables.
  always_comb begin
    seg_next = seg_reg;
    en_next  = tdd_pkg::EN_OFF;
    dot_next = dot_reg;
    case (scan_index)
      tdd_pkg::SCAN_TENTHS: begin
        seg_next = tdd_pkg::seg_pattern(digit_tenths);
        en_next  = tdd_pkg::EN_TENTHS;
        dot_next = 1'b1;
      end
      tdd_pkg::SCAN_UNITS: begin
        seg_next = tdd_pkg::seg_pattern(digit_units);
        en_next  = tdd_pkg::EN_UNITS;
        dot_next = 1'b0;
      end
      tdd_pkg::SCAN_TENS: begin
        seg_next = tdd_pkg::seg_pattern(digit_tens);
        en_next  = tdd_pkg::EN_TENS;
        dot_next = 1'b0;
      end
      default: begin
      end
    endcase
    if ({1'b0, scan_index} < SCAN_LAST) begin
      scan_next = scan_index + SW'(1);
    end else begin
      scan_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index   <= '0;
      digit_tenths <= '0;
      digit_units  <= '0;
      digit_tens   <= '0;
      temp_reg     <= '0;
      red_on       <= 1'b0;
      green_on     <= 1'b0;
      blue_on      <= 1'b0;
      duty_reg     <= '0;
      seg_reg      <= '0;
      en_reg       <= tdd_pkg::EN_OFF;
      dot_reg      <= 1'b0;
    end else if (commit) begin
      if (kind == tdd_pkg::REQ_SAMPLE) begin
        digit_tenths <= meas.tenths;
        digit_units  <= meas.units;
        digit_tens   <= meas.tens;
        temp_reg     <= meas.temp;
        red_on       <= meas.red;
        green_on     <= meas.green;
        blue_on      <= meas.blue;
        duty_reg     <= meas.duty;
      end else begin
        seg_reg    <= seg_next;
        en_reg     <= en_next;
        dot_reg    <= dot_next;
        scan_index <= scan_next;
      end
    end
  end

  assign segments     = seg_reg;
  assign digit_enable = en_reg;
  assign dot          = dot_reg;
  assign red_level    = {tdd_pkg::LEVEL_W{red_on}};
  assign green_level  = {tdd_pkg::LEVEL_W{green_on}};
  assign blue_level   = {tdd_pkg::LEVEL_W{blue_on}};
  assign servo_duty   = duty_reg;
  assign temp_tenths  = temp_reg;

endmodule

### sv/tdd_checker.sv
// ----------------------------------------------------------------------------
// Thermometer display driver port checker
// Watches the result channel for hold, reset, display, level and range rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tdd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [tdd_pkg::EN_W-1:0]    en;
  logic                        dot;
  logic [tdd_pkg::LEVEL_W-1:0] red, green, blue;
  logic [tdd_pkg::TEMP_W-1:0]  temp;

  assign en    = m_axis_tdata[9:7];
  assign dot   = m_axis_tdata[10];
  assign red   = m_axis_tdata[18:11];
  assign green = m_axis_tdata[26:19];
  assign blue  = m_axis_tdata[34:27];
  assign temp  = m_axis_tdata[62:51];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // At most one digit is driven, and the decimal point only with the tenths.
  a_display: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(en) && (!dot || en == tdd_pkg::EN_TENTHS))
    else $error("bad digit enable or decimal point");

  // Levels are fully on or off, and blue is never mixed with another color.
  a_levels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (red == 8'h00 || red == 8'hFF) &&
                      (green == 8'h00 || green == 8'hFF) &&
                      (blue == 8'h00 || blue == 8'hFF) &&
                      (blue == 8'h00 || (red == 8'h00 && green == 8'h00)))
    else $error("bad LED levels");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> temp <= tdd_pkg::FULL_SCALE_TENTHS)
    else $error("temperature above full scale");

endmodule

bind thermometer_display_driver tdd_checker u_tdd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_thermometer_display_driver.sv
// ----------------------------------------------------------------------------
// Thermometer display driver testbench
// Drives sample and scan-tick items through the stream input, reconfigures
// thresholds and servo widths between phases, and checks each result against
// a planned word or a cycle-free model of display, LED color and servo duty logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_thermometer_display_driver;
  import tdd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
  localparam logic [LEVEL_W-1:0]   LEVEL_ON     = 8'd255;
  localparam int unsigned          ADC_FULL     = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int unsigned          PERIOD_US    = 20000;
  localparam logic [WIDTH_W-1:0]   WIDTH_TOP    = 15'h7FFF;
  localparam logic [THRESH_W-1:0]  THRESH_TOP   = 12'hFFF;
  // Segment patterns of the digits 0..9, digit 0 in the lowest seven bits.
  localparam logic [69:0] SEG_DIGITS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                        7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  // One result word, declared from the top bit down so it overlays tdata.
  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [DUTY_W-1:0]  duty;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
    logic               dot;
    logic [EN_W-1:0]    en;
    logic [SEG_W-1:0]   seg;
  } display_word_t;

  typedef enum {ROW_SAMPLE, ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           data;
    bit                    typed;
    display_word_t         want;
  } plan_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata;   // sample
  logic                         s_axis_tuser;   // req_type
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // segments, digit_enable, dot, red_level, green_level, blue_level,
  // servo_duty, temp_tenths
  logic [OUT_TDATA_W-1:0]       m_axis_tdata;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  // Model state of the block.
  tdd_cfg_t             cfg_now;
  logic [SCAN_W-1:0]    scan_pos;
  logic [DIGIT_W-1:0]   dig_tenths, dig_units, dig_tens;
  logic [TEMP_W-1:0]    temp_now;
  logic [LEVEL_W-1:0]   red_now, green_now, blue_now;
  logic [DUTY_W-1:0]    duty_now;
  logic [SEG_W-1:0]     shown_seg;
  logic [EN_W-1:0]      shown_en;
  logic                 shown_dot;

  display_word_t        pending_q[$];
  bit                   typed_next;
  display_word_t        typed_word;
  bit                   hold_go;
  int                   error_count;

  thermometer_display_driver dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [SEG_W-1:0] digit_segments(input logic [DIGIT_W-1:0] d);
    return (d < 10) ? SEG_DIGITS[d*7 +: 7] : '0;
  endfunction

  // Advances the model by one item and returns the word the block should emit.
  function automatic display_word_t thermo_step(input logic req, input logic [15:0] raw);
    display_word_t w;
    logic [31:0]   t;
    logic [WIDTH_W-1:0] width;
    logic [47:0]   duty;
    if (req == REQ_TICK) begin
      case (scan_pos)
        SCAN_TENTHS: begin
          shown_seg = digit_segments(dig_tenths); shown_en = EN_TENTHS; shown_dot = 1'b1;
        end
        SCAN_UNITS: begin
          shown_seg = digit_segments(dig_units); shown_en = EN_UNITS; shown_dot = 1'b0;
        end
        SCAN_TENS: begin
          shown_seg = digit_segments(dig_tens); shown_en = EN_TENS; shown_dot = 1'b0;
        end
        default: shown_en = EN_OFF;
      endcase
      scan_pos = (scan_pos >= SCAN_TENS) ? SCAN_TENTHS : scan_pos + 1'b1;
    end else begin
      t = (32'(raw[SAMPLE_BITS_DEF-1:0]) * FULL_SCALE_TENTHS) / ADC_FULL;
      temp_now = t[TEMP_W-1:0];
      // The chains test in fixed order, so unordered thresholds still resolve.
      if (t < cfg_now.low) begin
        red_now = '0; green_now = '0; blue_now = LEVEL_ON;
      end else if (t < cfg_now.mid) begin
        red_now = '0; green_now = LEVEL_ON; blue_now = '0;
      end else if (t < cfg_now.high) begin
        red_now = LEVEL_ON; green_now = LEVEL_ON; blue_now = '0;
      end else begin
        red_now = LEVEL_ON; green_now = '0; blue_now = '0;
      end
      if (t < cfg_now.low) width = cfg_now.w_closed;
      else if (t < cfg_now.mid || t < cfg_now.high) width = cfg_now.w_mid;
      else width = cfg_now.w_open;
      duty = (48'(width) * DUTY_MAX) / PERIOD_US;
      duty_now = (duty > DUTY_MAX) ? DUTY_MAX : duty[DUTY_W-1:0];
      dig_tens   = DIGIT_W'((t / 100) % 10);
      dig_units  = DIGIT_W'((t / 10) % 10);
      dig_tenths = DIGIT_W'(t % 10);
    end
    w.seg = shown_seg; w.en = shown_en; w.dot = shown_dot;
    w.red = red_now; w.green = green_now; w.blue = blue_now;
    w.duty = duty_now; w.temp = temp_now;
    return w;
  endfunction

  function automatic display_word_t word(input logic [6:0] seg, input logic [2:0] en,
                                         input logic dot, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b,
                                         input logic [15:0] duty, input logic [11:0] temp);
    display_word_t w;
    w.seg = seg; w.en = en; w.dot = dot; w.red = r; w.green = g; w.blue = b;
    w.duty = duty; w.temp = temp;
    return w;
  endfunction

  function automatic plan_row_t row(input row_kind_e k, input logic [2:0] idx,
                                    input logic [15:0] d, input bit typed,
                                    input display_word_t want);
    plan_row_t r;
    r.kind = k; r.idx = idx; r.data = d; r.typed = typed; r.want = want;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Scoreboard: results are checked before the item accepted at the same edge
  // is predicted, since that item must pass the block's registers first.
  always @(posedge clk) begin : watch
    display_word_t got, want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW_THRESHOLD:  cfg_now.low      = cfg_data[THRESH_W-1:0];
          REG_MID_THRESHOLD:  cfg_now.mid      = cfg_data[THRESH_W-1:0];
          REG_HIGH_THRESHOLD: cfg_now.high     = cfg_data[THRESH_W-1:0];
          REG_WIDTH_CLOSED:   cfg_now.w_closed = cfg_data[WIDTH_W-1:0];
          REG_WIDTH_MID:      cfg_now.w_mid    = cfg_data[WIDTH_W-1:0];
          REG_WIDTH_OPEN:     cfg_now.w_open   = cfg_data[WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(display_word_t)-1:0];
        if (pending_q.size() == 0) begin
          error_count++;
          $display("%0t ns: result with none expected, expected nothing, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = pending_q.pop_front();
          check_field("segments",     32'(want.seg),   32'(got.seg));
          check_field("digit_enable", 32'(want.en),    32'(got.en));
          check_field("dot",          32'(want.dot),   32'(got.dot));
          check_field("red_level",    32'(want.red),   32'(got.red));
          check_field("green_level",  32'(want.green), 32'(got.green));
          check_field("blue_level",   32'(want.blue),  32'(got.blue));
          check_field("servo_duty",   32'(want.duty),  32'(got.duty));
          check_field("temp_tenths",  32'(want.temp),  32'(got.temp));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = thermo_step(s_axis_tuser, s_axis_tdata);
        pending_q.push_back(typed_next ? typed_word : want);
      end
    end
  end

  // Receiver: rotates through its own stall patterns; a long hold-off on request.
  initial begin : receiver
    int rcv_cycle;
    rcv_cycle = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      rcv_cycle++;
      if (hold_go) begin
        m_axis_tready <= 1'b0;
        repeat (64) @(negedge clk);
        hold_go = 1'b0;
      end else begin
        case ((rcv_cycle / 211) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (rcv_cycle % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Every handshake task starts and ends at a falling edge.
  task automatic send_item(input logic req, input logic [15:0] d, input bit typed,
                           input display_word_t want);
    typed_next = typed;
    typed_word = want;
    s_axis_tuser  <= req;
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Threshold writes carry random junk above bit 11, which the block drops.
  task automatic apply_setting(input tdd_cfg_t c);
    write_reg(REG_LOW_THRESHOLD,  {3'($urandom_range(0, 7)), c.low});
    write_reg(REG_MID_THRESHOLD,  {3'($urandom_range(0, 7)), c.mid});
    write_reg(REG_HIGH_THRESHOLD, {3'($urandom_range(0, 7)), c.high});
    write_reg(REG_WIDTH_CLOSED,   c.w_closed);
    write_reg(REG_WIDTH_MID,      c.w_mid);
    write_reg(REG_WIDTH_OPEN,     c.w_open);
    write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, 15'($urandom));
  endtask

  // Returns {req_type, sample}; some samples cluster around the live thresholds.
  function automatic logic [16:0] pick_item();
    int s;
    logic [THRESH_W-1:0] thr;
    logic [3:0] junk;
    junk = 4'($urandom);
    if ($urandom_range(0, 99) < 35) return {REQ_TICK, 16'($urandom)};
    case ($urandom_range(0, 9))
      0: s = $urandom_range(0, 1) ? ADC_FULL : 0;
      1, 2, 3: begin
        case ($urandom_range(0, 2))
          0:       thr = cfg_now.low;
          1:       thr = cfg_now.mid;
          default: thr = cfg_now.high;
        endcase
        s = (int'(thr) * ADC_FULL + FULL_SCALE_TENTHS - 1) / FULL_SCALE_TENTHS
            + int'($urandom_range(0, 4)) - 2;
        if (s < 0) s = 0;
        if (s > ADC_FULL) s = ADC_FULL;
      end
      default: s = $urandom_range(0, ADC_FULL);
    endcase
    return {REQ_SAMPLE, junk, 12'(s)};
  endfunction

  initial begin : stimulus
    plan_row_t     plan[$];
    tdd_cfg_t      c;
    logic [16:0]   it;
    logic [THRESH_W-1:0] tmp;
    int            burst_left, gap_max;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_SAMPLE;
    cfg_we = 1'b0;
    cfg_index = REG_LOW_THRESHOLD;
    cfg_data = '0;
    hold_go = 1'b0;
    typed_next = 1'b0;
    typed_word = '0;
    error_count = 0;
    cfg_now = {LOW_THRESHOLD_RST, MID_THRESHOLD_RST, HIGH_THRESHOLD_RST,
               WIDTH_CLOSED_RST, WIDTH_MID_RST, WIDTH_OPEN_RST};
    scan_pos = SCAN_TENTHS;
    {dig_tenths, dig_units, dig_tens} = '0;
    temp_now = '0;
    {red_now, green_now, blue_now} = '0;
    duty_now = '0;
    shown_seg = '0; shown_en = EN_OFF; shown_dot = 1'b0;

    // Directed part: LEDs off and zero duty after reset, full-scale ends, wrap of
    // the scan, samples with bits above the converter width, threshold edges,
    // saturating duty, unused register indexes and unordered thresholds.
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 1,
                       word(7'h3F, EN_TENTHS, 1, 0, 0, 0, 0, 0)));
    plan.push_back(row(ROW_SAMPLE, 0, 16'h0000, 1,
                       word(7'h3F, EN_TENTHS, 1, 0, 0, LEVEL_ON, 16'd3276, 0)));
    plan.push_back(row(ROW_SAMPLE, 0, 16'h0FFF, 1,
                       word(7'h3F, EN_TENTHS, 1, LEVEL_ON, 0, 0, 16'd6553, 12'd3300)));
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 1,
                       word(7'h3F, EN_UNITS, 0, LEVEL_ON, 0, 0, 16'd6553, 12'd3300)));
    plan.push_back(row(ROW_TICK,   0, 16'hFFFF, 1,
                       word(7'h4F, EN_TENS, 0, LEVEL_ON, 0, 0, 16'd6553, 12'd3300)));
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 1,
                       word(7'h3F, EN_TENTHS, 1, LEVEL_ON, 0, 0, 16'd6553, 12'd3300)));
    plan.push_back(row(ROW_SAMPLE, 0, 16'hF000, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'hFFFF, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd285, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd286, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd310, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd311, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd335, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd336, 0, '0));
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 0, '0));
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 0, '0));
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_LOW_THRESHOLD, 16'h7FFF, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_WIDTH_CLOSED,  16'h7FFF, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_UNUSED_6,      16'h7FFF, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_UNUSED_7,      16'h0000, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'h0FFF, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_LOW_THRESHOLD,  16'd100, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_MID_THRESHOLD,  16'd50, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_HIGH_THRESHOLD, 16'd300, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_WIDTH_MID,      16'd0, 0, '0));
    plan.push_back(row(ROW_WRITE,  REG_WIDTH_OPEN,     16'd20000, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd248, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd500, 0, '0));
    plan.push_back(row(ROW_SAMPLE, 0, 16'd62, 0, '0));
    plan.push_back(row(ROW_TICK,   0, 16'h0000, 0, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data[CFG_DATA_W-1:0]);
      end else begin
        send_item(plan[i].kind == ROW_TICK ? REQ_TICK : REQ_SAMPLE, plan[i].data,
                  plan[i].typed, plan[i].want);
        pause($urandom_range(0, 2));
      end
    end

    burst_left = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          c.low = THRESH_W'($urandom_range(0, FULL_SCALE_TENTHS));
          c.mid = THRESH_W'($urandom_range(0, FULL_SCALE_TENTHS));
          c.high = THRESH_W'($urandom_range(0, FULL_SCALE_TENTHS));
          if (c.low > c.mid) begin tmp = c.low; c.low = c.mid; c.mid = tmp; end
          if (c.mid > c.high) begin tmp = c.mid; c.mid = c.high; c.high = tmp; end
          if (c.low > c.mid) begin tmp = c.low; c.low = c.mid; c.mid = tmp; end
          c.w_closed = WIDTH_W'($urandom_range(0, PERIOD_US));
          c.w_mid = WIDTH_W'($urandom_range(0, PERIOD_US));
          c.w_open = WIDTH_W'($urandom_range(0, PERIOD_US));
        end
        1: begin
          c.low = 12'($urandom); c.mid = 12'($urandom); c.high = 12'($urandom);
          c.w_closed = 15'($urandom); c.w_mid = 15'($urandom); c.w_open = 15'($urandom);
        end
        2: begin
          if (phase == 2) begin
            c.low = '0; c.mid = '0; c.high = '0;
            c.w_closed = '0; c.w_mid = 15'(PERIOD_US); c.w_open = WIDTH_TOP;
          end else begin
            c.low = THRESH_TOP; c.mid = THRESH_TOP; c.high = THRESH_TOP;
            c.w_closed = WIDTH_TOP; c.w_mid = '0; c.w_open = 15'(PERIOD_US);
          end
        end
        default: c = {LOW_THRESHOLD_RST, MID_THRESHOLD_RST, HIGH_THRESHOLD_RST,
                      WIDTH_CLOSED_RST, WIDTH_MID_RST, WIDTH_OPEN_RST};
      endcase
      apply_setting(c);

      if (phase == 2) begin
        // Output held off while items keep coming, so the pipeline backs up.
        hold_go = 1'b1;
        repeat (40) begin
          it = pick_item();
          send_item(it[16], it[15:0], 0, '0);
        end
      end

      gap_max = (phase % 3 == 0) ? 0 : 12;
      for (int n = 0; n < 250; n++) begin
        it = pick_item();
        send_item(it[16], it[15:0], 0, '0);
        if (n == 125) drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          pause($urandom_range(0, gap_max));
        end else begin
          burst_left--;
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
sv/tdd_pkg.sv
sv/tdd_convert.sv
sv/tdd_classify.sv
sv/tdd_display.sv
sv/thermometer_display_driver.sv
sv/tdd_checker.sv
tb/sv/tb_thermometer_display_driver.sv
